@@ src/mp_pkg.sv @@
package mp_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int ELEM_W      = 16;
	localparam int PERM_W      = 32;
	localparam int SIZE_W      = 4;

	// datapath operations issued by the sequencer
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_PUSH,
		OP_POP,
		OP_FIN,
		OP_BMUL,
		OP_BSUM,
		OP_TMUL,
		OP_TACC,
		OP_VAL_E0,
		OP_OUT
	} op_t;

	// store read address selects
	typedef enum logic [2:0] {
		RD_NONE,
		RD_B00,
		RD_B11,
		RD_B01,
		RD_B10,
		RD_TERM,
		RD_ONE
	} rd_t;

	typedef struct packed {
		op_t        op;
		rd_t        rd;
		logic       cap_en;
		logic [1:0] cap_idx;
	} cmd_t;

	typedef struct packed {
		logic load_last;
		logic found;
		logic push_base;
		logic lvl_zero;
		logic n_one;
		logic n_two;
	} stat_t;

	// clamp a 34-bit signed sum to signed 32 bits
	function automatic logic signed [PERM_W-1:0] sat34(input logic signed [PERM_W+1:0] v);
		logic signed [PERM_W-1:0] r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[PERM_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ src/matrix_permanent.sv @@
// Channel | Dir | Bits | Contents
// s_*     | in  | 16   | element (signed Q1.15), row-major
// m_*     | out | 32   | permanent (signed Q17.15, saturated)
// cfg_*   | in  | 4    | matrix_size
// An n x n matrix is loaded as n*n input words, then the permanent is
// computed by a sequencer walking the first-row expansion on an element store
// with one read port.
// Input is blocked while computing; a finished word may wait on m_tready while
// the next matrix loads. arst_n clears the load count and sets size to one.
module matrix_permanent #(
	parameter int MAX_DIM = mp_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [mp_pkg::ELEM_W-1:0]    s_tdata,   // [15:0] element
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [mp_pkg::PERM_W-1:0]    m_tdata,   // [31:0] permanent
	input  logic                         cfg_we,
	input  logic [mp_pkg::SIZE_W-1:0]    cfg_wdata
);
	import mp_pkg::*;

	cmd_t                     cmd;
	stat_t                    stat;
	logic signed [PERM_W-1:0] perm;

	mp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mp_dpath #(.MAX_DIM(MAX_DIM)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.element   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.permanent (perm)
	);

	assign m_tdata = perm;

`ifndef SYNTHESIS
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOAD) |-> (s_tvalid && s_tready))
		else $error("store write without accepted word");

	a_out_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |=> m_tvalid)
		else $error("result loaded but not presented");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_START) |-> !s_tready)
		else $error("input open while computing");
`endif

endmodule

@@ src/mp_ram.sv @@
module mp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/mp_ctrl.sv @@
module mp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  mp_pkg::stat_t stat,
	output mp_pkg::cmd_t  cmd
);
	import mp_pkg::*;

	typedef enum logic [4:0] {
		S_LOAD, S_START, S_SCAN, S_POP, S_FIN,
		S_B0, S_B1, S_B2, S_B3, S_B4, S_BMUL, S_BSUM,
		S_T0, S_T1, S_TMUL, S_TACC,
		S_ONE0, S_ONE1, S_ONE2, S_OUT
	} state_t;

	state_t state_q, state_d;
	logic   out_free;

	assign s_tready = (state_q == S_LOAD);
	assign out_free = !m_tvalid || m_tready;

	// command decode and next state
	always_comb begin
		cmd     = '{op: OP_NONE, rd: RD_NONE, cap_en: 1'b0, cap_idx: 2'd0};
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (s_tvalid) begin
					cmd.op = OP_LOAD;
					if (stat.load_last) state_d = S_START;
				end
			end
			S_START: begin
				cmd.op = OP_START;
				if (stat.n_one)      state_d = S_ONE0;
				else if (stat.n_two) state_d = S_B0;
				else                 state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.found) begin
					cmd.op  = OP_PUSH;
					state_d = stat.push_base ? S_B0 : S_SCAN;
				end else begin
					state_d = stat.lvl_zero ? S_FIN : S_POP;
				end
			end
			S_POP: begin
				cmd.op  = OP_POP;
				state_d = S_T0;
			end
			S_FIN: begin
				cmd.op  = OP_FIN;
				state_d = S_OUT;
			end
			S_B0: begin
				cmd.rd  = RD_B00;
				state_d = S_B1;
			end
			S_B1: begin
				cmd.rd      = RD_B11;
				cmd.cap_en  = 1'b1;
				cmd.cap_idx = 2'd0;
				state_d     = S_B2;
			end
			S_B2: begin
				cmd.rd      = RD_B01;
				cmd.cap_en  = 1'b1;
				cmd.cap_idx = 2'd1;
				state_d     = S_B3;
			end
			S_B3: begin
				cmd.rd      = RD_B10;
				cmd.cap_en  = 1'b1;
				cmd.cap_idx = 2'd2;
				state_d     = S_B4;
			end
			S_B4: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_idx = 2'd3;
				state_d     = S_BMUL;
			end
			S_BMUL: begin
				cmd.op  = OP_BMUL;
				state_d = S_BSUM;
			end
			S_BSUM: begin
				cmd.op  = OP_BSUM;
				state_d = stat.n_two ? S_OUT : S_T0;
			end
			S_T0: begin
				cmd.rd  = RD_TERM;
				state_d = S_T1;
			end
			S_T1: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_idx = 2'd0;
				state_d     = S_TMUL;
			end
			S_TMUL: begin
				cmd.op  = OP_TMUL;
				state_d = S_TACC;
			end
			S_TACC: begin
				cmd.op  = OP_TACC;
				state_d = S_SCAN;
			end
			S_ONE0: begin
				cmd.rd  = RD_ONE;
				state_d = S_ONE1;
			end
			S_ONE1: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_idx = 2'd0;
				state_d     = S_ONE2;
			end
			S_ONE2: begin
				cmd.op  = OP_VAL_E0;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

@@ src/mp_dpath.sv @@
module mp_dpath #(
	parameter int MAX_DIM = mp_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mp_pkg::SIZE_W-1:0]           cfg_wdata,
	input  logic signed [mp_pkg::ELEM_W-1:0]    element,
	input  mp_pkg::cmd_t                        cmd,
	output mp_pkg::stat_t                       stat,
	output logic signed [mp_pkg::PERM_W-1:0]    permanent
);
	import mp_pkg::*;

	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int COL_W  = $clog2(MAX_DIM + 1);
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	logic [SIZE_W-1:0]               size_q;
	logic [ADDR_W-1:0]               cnt_q;
	logic [IDX_W-1:0]                lvl_q;
	logic [MAX_DIM-1:0]              used_q;
	logic signed [PERM_W-1:0]        acc_q [MAX_DIM];
	logic [COL_W-1:0]                col_q [MAX_DIM];
	logic signed [PERM_W-1:0]        val_q;
	logic signed [ELEM_W-1:0]        e_q [4];
	logic signed [2*ELEM_W-1:0]      p1_q, p2_q;
	logic signed [ELEM_W+PERM_W-1:0] tp_q;

	logic [COL_W-1:0]         dim;
	logic [CNT_W-1:0]         total;
	logic [COL_W-1:0]         col_cur;
	logic                     found;
	logic [IDX_W-1:0]         fcol, c0, c1;
	logic [COL_W-1:0]         brow;
	logic [ADDR_W-1:0]        raddr;
	logic [ELEM_W-1:0]        rdata;
	logic signed [PERM_W:0]   bsum;
	logic signed [PERM_W:0]   term;
	logic signed [PERM_W+1:0] asum;

	// effective dimension: zero acts as one, clamp at MAX_DIM
	always_comb begin
		if (size_q == '0) begin
			dim = COL_W'(1);
		end else if (size_q > SIZE_W'(MAX_DIM)) begin
			dim = COL_W'(MAX_DIM);
		end else begin
			dim = COL_W'(size_q);
		end
	end

	assign total   = CNT_W'(dim) * CNT_W'(dim);
	assign col_cur = col_q[lvl_q];
	assign brow    = dim - COL_W'(2);

	// next unused column at or after the level's column pointer
	always_comb begin
		found = 1'b0;
		fcol  = '0;
		for (int c = 0; c < MAX_DIM; c++) begin
			if (!found && !used_q[c] && COL_W'(c) >= col_cur && COL_W'(c) < dim) begin
				found = 1'b1;
				fcol  = IDX_W'(c);
			end
		end
	end

	// first two unused columns for the 2x2 minor
	always_comb begin
		c0   = '0;
		c1   = '0;
		for (int c = MAX_DIM - 1; c >= 0; c--) begin
			if (!used_q[c] && COL_W'(c) < dim) begin
				c1 = c0;
				c0 = IDX_W'(c);
			end
		end
	end

	function automatic logic [ADDR_W-1:0] addr_of(input logic [COL_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [COL_W-1:0] n);
		logic [2*COL_W-1:0] a;
		a = (2*COL_W)'(row) * (2*COL_W)'(n) + (2*COL_W)'(col);
		return a[ADDR_W-1:0];
	endfunction

	// store read address
	always_comb begin
		unique case (cmd.rd)
			RD_B00:  raddr = addr_of(brow, COL_W'(c0), dim);
			RD_B11:  raddr = addr_of(brow + COL_W'(1), COL_W'(c1), dim);
			RD_B01:  raddr = addr_of(brow, COL_W'(c1), dim);
			RD_B10:  raddr = addr_of(brow + COL_W'(1), COL_W'(c0), dim);
			RD_TERM: raddr = addr_of(COL_W'(lvl_q), col_cur, dim);
			default: raddr = '0;
		endcase
	end

	mp_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (cmd.op == OP_LOAD),
		.waddr (cnt_q),
		.wdata (element),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign bsum = {p1_q[2*ELEM_W-1], p1_q} + {p2_q[2*ELEM_W-1], p2_q};
	assign term = tp_q[ELEM_W+PERM_W-1:15];
	assign asum = {{2{acc_q[lvl_q][PERM_W-1]}}, acc_q[lvl_q]} + {term[PERM_W], term};

	assign stat.load_last = (CNT_W'(cnt_q) == total - CNT_W'(1));
	assign stat.found     = found;
	assign stat.push_base = (COL_W'(lvl_q) + COL_W'(3) == dim);
	assign stat.lvl_zero  = (lvl_q == '0);
	assign stat.n_one     = (dim == COL_W'(1));
	assign stat.n_two     = (dim == COL_W'(2));

	// control registers: size, load count, level, used columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(1);
			cnt_q  <= '0;
			lvl_q  <= '0;
			used_q <= '0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
				cnt_q  <= '0;
			end else if (cmd.op == OP_LOAD) begin
				cnt_q <= stat.load_last ? '0 : cnt_q + ADDR_W'(1);
			end
			unique case (cmd.op)
				OP_START: begin
					lvl_q  <= '0;
					used_q <= '0;
				end
				OP_PUSH: begin
					used_q[fcol] <= 1'b1;
					if (!stat.push_base) lvl_q <= lvl_q + IDX_W'(1);
				end
				OP_POP:  lvl_q <= lvl_q - IDX_W'(1);
				OP_TACC: used_q[col_cur[IDX_W-1:0]] <= 1'b0;
				default: ;
			endcase
		end
	end

	// arithmetic and per-level registers
	always_ff @(posedge clk) begin
		if (cmd.cap_en) e_q[cmd.cap_idx] <= rdata;
		unique case (cmd.op)
			OP_START: begin
				acc_q[0] <= '0;
				col_q[0] <= '0;
			end
			OP_PUSH: begin
				col_q[lvl_q] <= COL_W'(fcol);
				if (!stat.push_base) begin
					acc_q[lvl_q + IDX_W'(1)] <= '0;
					col_q[lvl_q + IDX_W'(1)] <= '0;
				end
			end
			OP_POP:    val_q <= acc_q[lvl_q];
			OP_FIN:    val_q <= acc_q[0];
			OP_BMUL: begin
				p1_q <= e_q[0] * e_q[1];
				p2_q <= e_q[2] * e_q[3];
			end
			// shifted 2x2 sum always fits; sign-extend the slice
			OP_BSUM:   val_q <= PERM_W'($signed(bsum[PERM_W:15]));
			OP_TMUL:   tp_q <= e_q[0] * val_q;
			OP_TACC: begin
				acc_q[lvl_q] <= sat34(asum);
				col_q[lvl_q] <= col_cur + COL_W'(1);
			end
			OP_VAL_E0: val_q <= PERM_W'(e_q[0]);
			OP_OUT:    permanent <= val_q;
			default: ;
		endcase
	end

endmodule
